[sv/adpx_pkg.sv]
// Shared constants for the additive differential XOR count pipeline.
`default_nettype none
package adpx_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int NUM_STATES    = 4;
  // state index = {borrow + 1, carry}; zero carry and zero borrow
  localparam logic [1:0] START_STATE = 2'd2;

endpackage
`default_nettype wire

[sv/adpx_bit_stage.sv]
// One pipeline stage: advances the carry/borrow automaton by one bit position.
`default_nettype none
module adpx_bit_stage #(
  parameter int WORD_BITS = 32,
  parameter int BIT_POS   = 0
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            in_valid,
  input  wire logic [WORD_BITS-1:0]                            in_a,
  input  wire logic [WORD_BITS-1:0]                            in_db,
  input  wire logic [WORD_BITS-1:0]                            in_dc,
  input  wire logic [adpx_pkg::NUM_STATES-1:0][WORD_BITS:0]    in_cnt,
  output logic                                                 out_valid,
  output logic      [WORD_BITS-1:0]                            out_a,
  output logic      [WORD_BITS-1:0]                            out_db,
  output logic      [WORD_BITS-1:0]                            out_dc,
  output logic      [adpx_pkg::NUM_STATES-1:0][WORD_BITS:0]    out_cnt
);
  import adpx_pkg::*;

  localparam int CNT_W = WORD_BITS + 1;

  logic                                                abit;
  logic                                                dbbit;
  logic                                                dcbit;
  logic [NUM_STATES-1:0][CNT_W-1:0]                    cnt_next;
  logic [2*NUM_STATES-1:0]                             hit;
  logic [2*NUM_STATES-1:0][1:0]                        dest;
  logic [NUM_STATES-1:0][2*NUM_STATES-1:0][CNT_W-1:0]  term;
  logic [1:0]                                          ui;
  logic                                                xb;
  logic                                                carry;
  logic                                                yb;
  logic                                                ncarry;
  logic                                                c1;
  logic                                                c2;
  logic [2:0]                                          diff;

  assign abit  = in_a[BIT_POS];
  assign dbbit = in_db[BIT_POS];
  assign dcbit = in_dc[BIT_POS];

  // per (state, x) transition: destination state and whether dc bit matches
  always_comb begin
    hit    = '0;
    dest   = '0;
    ui     = '0;
    xb     = 1'b0;
    carry  = 1'b0;
    yb     = 1'b0;
    ncarry = 1'b0;
    c1     = 1'b0;
    c2     = 1'b0;
    diff   = '0;
    for (int u = 0; u < NUM_STATES; u++) begin
      for (int x = 0; x < 2; x++) begin
        ui     = u[1:0];
        xb     = x[0];
        carry  = ui[0];
        yb     = xb ^ dbbit ^ carry;
        ncarry = (xb & dbbit) | (xb & carry) | (dbbit & carry);
        c1     = abit ^ xb;
        c2     = abit ^ yb;
        // c2 - c1 + borrow, offset so it stays in 0..3
        diff   = {2'b00, c2} + {2'b00, ui[1]} + 3'd1 - {2'b00, c1};
        dest[{ui, xb}] = {diff[1], ncarry};
        hit[{ui, xb}]  = (diff[0] == dcbit);
      end
    end
  end

  // balanced sum of the contributions landing in each destination state
  always_comb begin
    term     = '0;
    cnt_next = '0;
    for (int d = 0; d < NUM_STATES; d++) begin
      for (int i = 0; i < 2*NUM_STATES; i++) begin
        if (hit[i[2:0]] && (dest[i[2:0]] == d[1:0])) begin
          term[d[1:0]][i[2:0]] = in_cnt[i[2:1]];
        end
      end
    end
    for (int d = 0; d < NUM_STATES; d++) begin
      cnt_next[d[1:0]] = ((term[d[1:0]][0] + term[d[1:0]][1])
                        + (term[d[1:0]][2] + term[d[1:0]][3]))
                       + ((term[d[1:0]][4] + term[d[1:0]][5])
                        + (term[d[1:0]][6] + term[d[1:0]][7]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_a   <= in_a;
    out_db  <= in_db;
    out_dc  <= in_dc;
    out_cnt <= cnt_next;
  end

endmodule
`default_nettype wire

[sv/adpx_total.sv]
// Two-stage adder tree summing the four automaton path counts.
`default_nettype none
module adpx_total #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          in_valid,
  input  wire logic [adpx_pkg::NUM_STATES-1:0][WORD_BITS:0]  in_cnt,
  output logic                                               out_valid,
  output logic      [WORD_BITS:0]                            out_total
);
  import adpx_pkg::*;

  localparam int CNT_W = WORD_BITS + 1;

  logic             mid_valid;
  logic [CNT_W-1:0] sum_lo;
  logic [CNT_W-1:0] sum_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_lo    <= in_cnt[0] + in_cnt[1];
    sum_hi    <= in_cnt[2] + in_cnt[3];
    out_total <= sum_lo + sum_hi;
  end

endmodule
`default_nettype wire

[sv/adp_xor_fixed_input_count.sv]
// Top level: pipelined count of words b meeting an additive XOR differential.
//
// Usage: drive fixed_value, in_difference and out_difference and raise start
// for one cycle per item. busy is always low, so an item is taken on every
// cycle that start is high; back-to-back items enter one per clock.
// Each item flows through WORD_BITS bit stages, one bit of the carry/borrow
// automaton per stage, then a two-stage adder tree that sums the four path
// counts. done pulses for one cycle with match_count once the item has passed
// the bit stages and the adder tree; results leave in order of entry.
// Throughput is one item per cycle, set by the one-bit-per-stage pipeline.
// match_count / 2^WORD_BITS is the differential probability.
// Reset (rst, synchronous) clears all stage valid bits; items in flight are
// dropped and no done pulse follows them. The receiver must take each result
// in the cycle done is high; there is no output back-pressure.
`default_nettype none
module adp_xor_fixed_input_count #(
  parameter int WORD_BITS = adpx_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [WORD_BITS-1:0] fixed_value,
  input  wire logic [WORD_BITS-1:0] in_difference,
  input  wire logic [WORD_BITS-1:0] out_difference,
  output logic                      done,
  output logic      [WORD_BITS:0]   match_count
);
  import adpx_pkg::*;

  localparam int CNT_W   = WORD_BITS + 1;
  localparam int LATENCY = WORD_BITS + 2;

  logic                             stg_valid [WORD_BITS+1];
  logic [WORD_BITS-1:0]             stg_a     [WORD_BITS+1];
  logic [WORD_BITS-1:0]             stg_db    [WORD_BITS+1];
  logic [WORD_BITS-1:0]             stg_dc    [WORD_BITS+1];
  logic [NUM_STATES-1:0][CNT_W-1:0] stg_cnt   [WORD_BITS+1];

  assign busy = 1'b0;

  // one path in the zero-carry, zero-borrow state
  assign stg_cnt[0] = (NUM_STATES*CNT_W)'(1) << (CNT_W * int'(START_STATE));

  assign stg_valid[0] = start;
  assign stg_a[0]     = fixed_value;
  assign stg_db[0]    = in_difference;
  assign stg_dc[0]    = out_difference;

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_bit
    adpx_bit_stage #(
      .WORD_BITS(WORD_BITS),
      .BIT_POS  (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stg_valid[k]),
      .in_a     (stg_a[k]),
      .in_db    (stg_db[k]),
      .in_dc    (stg_dc[k]),
      .in_cnt   (stg_cnt[k]),
      .out_valid(stg_valid[k+1]),
      .out_a    (stg_a[k+1]),
      .out_db   (stg_db[k+1]),
      .out_dc   (stg_dc[k+1]),
      .out_cnt  (stg_cnt[k+1])
    );
  end

  adpx_total #(
    .WORD_BITS(WORD_BITS)
  ) u_total (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stg_valid[WORD_BITS]),
    .in_cnt   (stg_cnt[WORD_BITS]),
    .out_valid(done),
    .out_total(match_count)
  );

`ifndef SYNTHESIS
  // every taken item yields a done pulse after the fixed latency
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("item taken without a result after pipeline latency");

  // no result appears without an item taken the fixed latency earlier
  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  // a count never exceeds 2^WORD_BITS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (done && match_count[WORD_BITS]) |-> (match_count[WORD_BITS-1:0] == '0))
    else $error("match count above 2^WORD_BITS");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for adp_xor_fixed_input_count: bursty triples checked against a bit-serial path count.
module tb;
  import adpx_pkg::*;

  localparam int W = WORD_BITS_DEF;
  localparam int NUM_RANDOM = 1030;
  localparam int NUM_DIRECTED = 16;

  localparam logic [W-1:0] DIR_A [NUM_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
    32'h8000_0000, 32'h0000_0001, 32'hDEAD_BEEF, 32'h7FFF_FFFF};
  localparam logic [W-1:0] DIR_DB [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
    32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
    32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0000, 32'h8000_0001};
  localparam logic [W-1:0] DIR_DC [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
    32'h5555_5555, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h8000_0001, 32'h0000_0002, 32'hFFFF_FFFF, 32'h7FFF_FFFF};

  class count_scoreboard;
    logic [W:0] expected_counts [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function automatic logic [W:0] count_matching_words(logic [W-1:0] a, logic [W-1:0] db,
                                                        logic [W-1:0] dc);
      logic [63:0] paths [4];
      logic [63:0] nxt_paths [4];
      logic [63:0] total;
      int carry, bidx, y, ncarry, c1, c2, sum;
      foreach (paths[s]) paths[s] = '0;
      paths[START_STATE] = 64'd1;
      for (int pos = 0; pos < W; pos++) begin
        foreach (nxt_paths[s]) nxt_paths[s] = '0;
        for (int st = 0; st < NUM_STATES; st++) begin
          carry = st & 1;
          bidx = (st >> 1) & 1;
          for (int x = 0; x < 2; x++) begin
            y = x ^ int'(db[pos]) ^ carry;
            ncarry = (x + int'(db[pos]) + carry) >> 1;
            c1 = int'(a[pos]) ^ x;
            c2 = int'(a[pos]) ^ y;
            // c2 - c1 + borrow, offset so it stays in 0..3
            sum = c2 + bidx + 1 - c1;
            if ((sum & 1) == int'(dc[pos]))
              nxt_paths[((sum >> 1) & 1) * 2 + ncarry] += paths[st];
          end
        end
        paths = nxt_paths;
      end
      total = '0;
      foreach (paths[s]) total += paths[s];
      return total[W:0];
    endfunction

    function void note_item(logic [W-1:0] a, logic [W-1:0] db, logic [W-1:0] dc);
      expected_counts.push_back(count_matching_words(a, db, dc));
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_count(logic [W:0] got);
      logic [W:0] want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("match_count %0d with no item pending", got));
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) report_mismatch($sformatf("match_count %0d, want %0d", got, want));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic [W-1:0] fixed_value = '0;
  logic [W-1:0] in_difference = '0;
  logic [W-1:0] out_difference = '0;
  logic         busy;
  logic         done;
  logic [W:0]   match_count;

  count_scoreboard sb = new();

  always #4 clk = ~clk;

  adp_xor_fixed_input_count #(.WORD_BITS(W)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .fixed_value(fixed_value),
    .in_difference(in_difference),
    .out_difference(out_difference),
    .done(done),
    .match_count(match_count)
  );

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_item(fixed_value, in_difference, out_difference);
    if (!rst && done) sb.check_count(match_count);
  end

  task automatic send_item(logic [W-1:0] a, logic [W-1:0] db, logic [W-1:0] dc);
    start <= 1'b1;
    fixed_value <= a;
    in_difference <= db;
    out_difference <= dc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) begin
      fixed_value <= $urandom;
      in_difference <= $urandom;
      out_difference <= $urandom;
      @(posedge clk);
    end
  endtask

  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return W'($urandom_range(0, 15));
      1: return -W'($urandom_range(1, 16));
      2: return W'(1) << $urandom_range(0, W - 1);
      3: return $urandom & $urandom & $urandom;
      4: return $urandom | $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  // mostly triples with a known solution b, so counts are nonzero
  task automatic make_triple(output logic [W-1:0] a, output logic [W-1:0] db,
                             output logic [W-1:0] dc);
    logic [W-1:0] b;
    int kind;
    kind = $urandom_range(0, 9);
    a = pick_word();
    db = pick_word();
    b = $urandom;
    if (kind < 7) dc = (a ^ (b + db)) - (a ^ b);
    else if (kind == 7) dc = pick_word();
    else if (kind == 8) dc = db;
    else dc = -db;
  endtask

  initial begin
    logic [W-1:0] a, db, dc;
    int sent;
    int burst;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) send_item(DIR_A[i], DIR_DB[i], DIR_DC[i]);
    idle_for($urandom_range(1, 5));
    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      repeat (burst) begin
        make_triple(a, db, dc);
        send_item(a, db, dc);
        sent++;
      end
      if ($urandom_range(0, 4) != 0) idle_for($urandom_range(1, 12));
    end
    idle_for(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (W + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/adpx_pkg.sv
sv/adpx_bit_stage.sv
sv/adpx_total.sv
sv/adp_xor_fixed_input_count.sv
verif/tb.sv
